FILE: design/vlpd_pkg.sv
package vlpd_pkg;

    // Largest frame length the block ever accepts, independent of buffer_limit.
    localparam logic [12:0] MAX_MESSAGE = 13'd4096;

    // Reset value of the buffer_limit register.
    localparam logic [12:0] BUFFER_LIMIT_RESET = 13'd4096;

    // Command codes carried on s_tuser.
    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_CLOSED  = 2'd1;
    localparam logic [1:0] CMD_IO_FAIL = 2'd2;

    // Result kinds carried on m_tuser.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_VARINT   = 3'd1;
    localparam logic [2:0] ERR_TOO_BIG  = 3'd2;
    localparam logic [2:0] ERR_CLOSED   = 3'd3;
    localparam logic [2:0] ERR_IO       = 3'd4;

    // Index of the last header byte; that byte may not carry a continuation bit.
    localparam logic [2:0] LAST_HDR_IDX = 3'd4;

    // APB register map.
    localparam logic [2:0] ADDR_BUFFER_LIMIT = 3'd0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last;
        logic [12:0] frame_length;
        logic [2:0]  error_code;
    } result_t;

endpackage

FILE: design/vlpd_core.sv
module vlpd_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic [1:0]            command,
    input  logic [7:0]            in_byte,
    input  logic [12:0]           buffer_limit,
    output logic                  res_valid,
    output vlpd_pkg::result_t     res
);

    logic        in_payload_reg, in_payload_next;
    logic [12:0] acc_lo_reg, acc_lo_next;
    logic        acc_hi_reg, acc_hi_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [12:0] remaining_reg, remaining_next;
    logic [12:0] flen_reg, flen_next;

    logic [2:0]  idx_clip;
    logic [31:0] contrib;
    logic [12:0] lo_new;
    logic        hi_new;
    logic [12:0] rem_dec;

    assign idx_clip = (hdr_idx_reg > vlpd_pkg::LAST_HDR_IDX) ? vlpd_pkg::LAST_HDR_IDX
                                                             : hdr_idx_reg;

    // Seven data bits placed at 7*index; bits beyond 32 fall off.
    always_comb begin
        case (idx_clip)
            3'd0:    contrib = {25'd0, in_byte[6:0]};
            3'd1:    contrib = {18'd0, in_byte[6:0], 7'd0};
            3'd2:    contrib = {11'd0, in_byte[6:0], 14'd0};
            3'd3:    contrib = {4'd0, in_byte[6:0], 21'd0};
            default: contrib = {in_byte[3:0], 28'd0};
        endcase
    end

    assign lo_new  = acc_lo_reg | contrib[12:0];
    assign hi_new  = acc_hi_reg | (|contrib[31:13]);
    assign rem_dec = remaining_reg - 13'd1;

    always_comb begin
        in_payload_next   = in_payload_reg;
        acc_lo_next       = acc_lo_reg;
        acc_hi_next       = acc_hi_reg;
        hdr_idx_next      = hdr_idx_reg;
        remaining_next    = remaining_reg;
        flen_next         = flen_reg;
        res_valid         = 1'b0;
        res.kind          = vlpd_pkg::KIND_PAYLOAD;
        res.payload_byte  = 8'd0;
        res.last          = 1'b0;
        res.frame_length  = 13'd0;
        res.error_code    = vlpd_pkg::ERR_NONE;

        if (in_fire) begin
            case (command)
                vlpd_pkg::CMD_CLOSED, vlpd_pkg::CMD_IO_FAIL: begin
                    in_payload_next = 1'b0;
                    acc_lo_next     = 13'd0;
                    acc_hi_next     = 1'b0;
                    hdr_idx_next    = 3'd0;
                    remaining_next  = 13'd0;
                    flen_next       = 13'd0;
                    res_valid       = 1'b1;
                    res.kind        = vlpd_pkg::KIND_ERROR;
                    res.error_code  = (command == vlpd_pkg::CMD_CLOSED) ?
                                      vlpd_pkg::ERR_CLOSED : vlpd_pkg::ERR_IO;
                end
                vlpd_pkg::CMD_DATA: begin
                    if (in_payload_reg) begin
                        res_valid        = 1'b1;
                        res.payload_byte = in_byte;
                        if (rem_dec == 13'd0) begin
                            res.last         = 1'b1;
                            res.frame_length = flen_reg;
                            in_payload_next  = 1'b0;
                            acc_lo_next      = 13'd0;
                            acc_hi_next      = 1'b0;
                            hdr_idx_next     = 3'd0;
                            remaining_next   = 13'd0;
                            flen_next        = 13'd0;
                        end else begin
                            remaining_next = rem_dec;
                        end
                    end else if (in_byte[7]) begin
                        if (idx_clip >= vlpd_pkg::LAST_HDR_IDX) begin
                            acc_lo_next    = 13'd0;
                            acc_hi_next    = 1'b0;
                            hdr_idx_next   = 3'd0;
                            remaining_next = 13'd0;
                            flen_next      = 13'd0;
                            res_valid      = 1'b1;
                            res.kind       = vlpd_pkg::KIND_ERROR;
                            res.error_code = vlpd_pkg::ERR_VARINT;
                        end else begin
                            acc_lo_next  = lo_new;
                            acc_hi_next  = hi_new;
                            hdr_idx_next = idx_clip + 3'd1;
                        end
                    end else begin
                        acc_lo_next    = 13'd0;
                        acc_hi_next    = 1'b0;
                        hdr_idx_next   = 3'd0;
                        remaining_next = 13'd0;
                        flen_next      = 13'd0;
                        if (hi_new || (lo_new > buffer_limit) ||
                            (lo_new > vlpd_pkg::MAX_MESSAGE)) begin
                            res_valid      = 1'b1;
                            res.kind       = vlpd_pkg::KIND_ERROR;
                            res.error_code = vlpd_pkg::ERR_TOO_BIG;
                        end else if (lo_new == 13'd0) begin
                            res_valid = 1'b1;
                            res.kind  = vlpd_pkg::KIND_EMPTY;
                            res.last  = 1'b1;
                        end else begin
                            in_payload_next = 1'b1;
                            remaining_next  = lo_new;
                            flen_next       = lo_new;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            acc_lo_reg     <= 13'd0;
            acc_hi_reg     <= 1'b0;
            hdr_idx_reg    <= 3'd0;
            remaining_reg  <= 13'd0;
            flen_reg       <= 13'd0;
        end else begin
            in_payload_reg <= in_payload_next;
            acc_lo_reg     <= acc_lo_next;
            acc_hi_reg     <= acc_hi_next;
            hdr_idx_reg    <= hdr_idx_next;
            remaining_reg  <= remaining_next;
            flen_reg       <= flen_next;
        end
    end

endmodule

FILE: design/vlpd_out_reg.sv
module vlpd_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  vlpd_pkg::result_t     push_data,
    output logic                  can_push,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vlpd_pkg::result_t     out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    vlpd_pkg::result_t main_data_reg, main_data_next;
    vlpd_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop       = main_valid_reg & out_ready;
    assign can_push  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: design/varint_length_prefix_deframer_top.sv
// Varint length-prefixed deframer. Bytes arrive on the s_ stream with a command
// on s_tuser (data byte, peer close, I/O failure). Each frame opens with a
// little-endian base-128 varint length of up to five bytes; the payload bytes
// that follow come out on the m_ stream one transfer each, and the final one
// has m_tlast set and carries the frame length. An empty frame gives a single
// transfer of kind "empty" with m_tlast set. A header longer than five bytes,
// a length above buffer_limit or above 4096, a peer close and an I/O failure
// each give one error transfer, after which header parsing starts afresh.
// Header bytes other than the terminating one, and command code 3, give no
// output transfer. Rate: one input transfer per clock while the output stage
// has room; a result is registered in the output stage before it appears on
// the m_ side. The per-byte state update is a single registered step. A
// two-entry output stage holds a result pushed while the first entry waits
// on m_tready; s_tready falls once the second entry is full and rises again
// once an m_tready handshake frees it. The buffer_limit register sits at APB
// byte address 0.
module varint_length_prefix_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_tuser,   // [1:0] command

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [20:8] frame_length,
                                   // [23:21] error_code
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0]       buffer_limit_reg;
    logic              s_fire;
    logic              res_valid;
    vlpd_pkg::result_t res;
    vlpd_pkg::result_t out_data;

    // Configuration register. Writes land on the access phase; other
    // addresses are ignored and read back as zero.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_limit_reg <= vlpd_pkg::BUFFER_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == vlpd_pkg::ADDR_BUFFER_LIMIT)) begin
            buffer_limit_reg <= pwdata[12:0];
        end
    end

    assign prdata = (paddr == vlpd_pkg::ADDR_BUFFER_LIMIT) ? {19'd0, buffer_limit_reg}
                                                           : 32'd0;

    // An input transfer happens whenever s_tvalid is high and the output stage has room.
    assign s_fire = s_tvalid & s_tready;

    vlpd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (s_fire),
        .command      (s_tuser),
        .in_byte      (s_tdata),
        .buffer_limit (buffer_limit_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    vlpd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.error_code, out_data.frame_length, out_data.payload_byte};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule
